// File: rtl/core/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared widths, Modbus codes and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int BYTE_W = 8;
  localparam int REG_W  = 16;

  localparam int REG_COUNT_DEF     = 256;
  localparam int FRAME_BYTES_DEF   = 64;
  localparam int MAX_READ_REGS_DEF = 29;

  localparam logic [7:0] SLAVE_ADDR_RST = 8'h01;

  localparam logic [7:0] FN_COILS       = 8'h01;
  localparam logic [7:0] FN_INPUTS      = 8'h02;
  localparam logic [7:0] FN_READ_HOLD   = 8'h03;
  localparam logic [7:0] FN_WRITE_ONE   = 8'h06;
  localparam logic [7:0] FN_WRITE_MULTI = 8'h10;
  localparam logic [7:0] EXC_FLAG       = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FN = 8'h01;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One byte through the reflected CRC-16/MODBUS, eight shift steps.
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/mbrtu_frame_mem.sv
// ----------------------------------------------------------------------------
// mbrtu_frame_mem
// Frame byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mbrtu_frame_mem #(
  parameter int DEPTH = mbrtu_pkg::FRAME_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(DEPTH)-1:0]          waddr,
  input  logic [mbrtu_pkg::BYTE_W-1:0]      wdata,
  input  logic [$clog2(DEPTH)-1:0]          raddr,
  output logic [mbrtu_pkg::BYTE_W-1:0]      rdata
);
  import mbrtu_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/mbrtu_reg_mem.sv
// ----------------------------------------------------------------------------
// mbrtu_reg_mem
// Holding register array: single port, write or registered read per cycle.
// ----------------------------------------------------------------------------
module mbrtu_reg_mem #(
  parameter int DEPTH = mbrtu_pkg::REG_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              we,
  input  logic [$clog2(DEPTH)-1:0]          addr,
  input  logic [mbrtu_pkg::REG_W-1:0]       wdata,
  output logic [mbrtu_pkg::REG_W-1:0]       rdata
);
  import mbrtu_pkg::*;

  logic [REG_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/core/modbus_rtu_slave_register_server.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_register_server
// Modbus RTU slave serving holding registers (functions 03, 06 and 16).
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Word
// rx        in         rx_valid / rx_stall  rx_byte, frame_end
// tx        out        tx_valid / tx_stall  tx_byte, tx_last
// cfg       in         cfg_valid/cfg_ready  slave_address
//
// A frame_end byte starts processing with rx stalled throughout: a scan of the stored
// frame (ended at once for a short or overlong frame), a check state, the states S_WA,
// S_WB and S_WC per register of a block write, S_RREQ and S_RWAIT per register read
// ahead of its two data bytes, the response bytes while tx is not stalled, and a
// closing state. A stalled tx word holds the sequencer in place.
// After reset a clearing pass zeroes all REG_COUNT registers, rx stalled; cfg is always ready.
//
module modbus_rtu_slave_register_server #(
  parameter int REG_COUNT     = mbrtu_pkg::REG_COUNT_DEF,
  parameter int FRAME_BYTES   = mbrtu_pkg::FRAME_BYTES_DEF,
  parameter int MAX_READ_REGS = mbrtu_pkg::MAX_READ_REGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rx_valid,
  output logic                          rx_stall,
  input  logic [mbrtu_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                          frame_end,
  output logic                          tx_valid,
  input  logic                          tx_stall,
  output logic [mbrtu_pkg::BYTE_W-1:0]  tx_byte,
  output logic                          tx_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbrtu_pkg::BYTE_W-1:0]  slave_address
);
  import mbrtu_pkg::*;

  localparam int AW  = $clog2(FRAME_BYTES);
  localparam int LW  = $clog2(FRAME_BYTES + 1);
  localparam int RAW = $clog2(REG_COUNT);
  localparam int CW  = 8;
  localparam logic [16:0] REG_LIM = 17'(REG_COUNT);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SCAN, S_CHECK, S_WA, S_WB, S_WC,
    S_HEAD, S_RREQ, S_RWAIT, S_RHI, S_RLO, S_CRLO, S_CRHI, S_FIN
  } state_t;

  typedef enum logic [1:0] {K_EXC, K_READ, K_ECHO} kind_t;

  state_t state;
  kind_t  kind;

  logic [BYTE_W-1:0] slave_addr;
  logic [LW-1:0]     flen;
  logic              fovf;
  logic [LW-1:0]     rd_ptr;
  logic              dval;
  logic [LW-1:0]     didx;
  logic [BYTE_W-1:0] hdr [7];
  logic [BYTE_W-1:0] crc_lo_rx;
  logic [BYTE_W-1:0] crc_hi_rx;
  logic [15:0]       fcrc;
  logic [15:0]       tcrc;
  logic [2:0]        tidx;
  logic [RAW-1:0]    rptr;
  logic [CW-1:0]     rem;
  logic [AW-1:0]     fptr;
  logic [BYTE_W-1:0] whi;
  logic [RAW-1:0]    clr;

  logic [BYTE_W-1:0] frd;
  logic [AW-1:0]     fraddr;
  logic              fwe;
  logic [REG_W-1:0]  reg_rd;
  logic              reg_en;
  logic              reg_we;
  logic [RAW-1:0]    reg_addr;
  logic [REG_W-1:0]  reg_wdata;

  logic              rx_acc;
  logic              out_free;
  logic [15:0]       start;
  logic [15:0]       count;
  logic              hdr_ok;
  logic              fn_exc;
  logic              rd_ok;
  logic              w1_ok;
  logic              wn_ok;
  logic [BYTE_W-1:0] head_byte;
  logic [2:0]        head_end;

  assign cfg_ready = 1'b1;
  assign rx_stall  = (state != S_IDLE);
  assign rx_acc    = rx_valid && (state == S_IDLE);
  assign out_free  = !tx_valid || !tx_stall;
  assign fwe       = rx_acc && (flen < LW'(FRAME_BYTES));

  assign start = {hdr[2], hdr[3]};
  assign count = {hdr[4], hdr[5]};

  // Frame acceptance: station address, then the CRC in either byte order.
  assign hdr_ok = (hdr[0] == slave_addr)
                  && ((fcrc == {crc_hi_rx, crc_lo_rx}) || (fcrc == {crc_lo_rx, crc_hi_rx}));
  assign fn_exc = (hdr[1] == FN_COILS) || (hdr[1] == FN_INPUTS);
  assign rd_ok  = (hdr[1] == FN_READ_HOLD) && (flen >= LW'(8)) && (count != 16'd0)
                  && (count <= 16'(MAX_READ_REGS))
                  && (({1'b0, start} + {1'b0, count}) <= REG_LIM);
  assign w1_ok  = (hdr[1] == FN_WRITE_ONE) && (flen >= LW'(8)) && ({1'b0, start} < REG_LIM);
  // Block write: byte count must equal twice the count, and the data must end
  // before the two CRC bytes.
  assign wn_ok  = (hdr[1] == FN_WRITE_MULTI) && (flen >= LW'(9))
                  && ({9'd0, hdr[6]} == {count, 1'b0}) && (count != 16'd0)
                  && (({1'b0, start} + {1'b0, count}) <= REG_LIM)
                  && (({1'b0, count, 1'b0} + 18'd9) <= 18'(flen));

  always_comb begin
    case (state)
      S_WA:    fraddr = fptr;
      S_WB:    fraddr = fptr + AW'(1);
      default: fraddr = rd_ptr[AW-1:0];
    endcase
  end

  always_comb begin
    reg_en    = 1'b0;
    reg_we    = 1'b0;
    reg_addr  = rptr;
    reg_wdata = {whi, frd};
    case (state)
      S_CLR: begin
        reg_en    = 1'b1;
        reg_we    = 1'b1;
        reg_addr  = clr;
        reg_wdata = '0;
      end
      S_CHECK: begin
        if (hdr_ok && w1_ok) begin
          reg_en    = 1'b1;
          reg_we    = 1'b1;
          reg_addr  = start[RAW-1:0];
          reg_wdata = count;
        end
      end
      S_WC: begin
        reg_en = 1'b1;
        reg_we = 1'b1;
      end
      S_RREQ: begin
        reg_en = 1'b1;
      end
      default: begin
        reg_en = 1'b0;
      end
    endcase
  end

  // Response header bytes ahead of register data or the CRC.
  always_comb begin
    head_end = (kind == K_ECHO) ? 3'd5 : 3'd2;
    case (tidx)
      3'd0: head_byte = slave_addr;
      3'd1: begin
        case (kind)
          K_EXC:   head_byte = EXC_FLAG + hdr[1];
          K_READ:  head_byte = FN_READ_HOLD;
          default: head_byte = hdr[1];
        endcase
      end
      3'd2: begin
        case (kind)
          K_EXC:   head_byte = EXC_ILLEGAL_FN;
          K_READ:  head_byte = {count[6:0], 1'b0};
          default: head_byte = hdr[2];
        endcase
      end
      default: head_byte = hdr[tidx];
    endcase
  end

  mbrtu_frame_mem #(.DEPTH(FRAME_BYTES)) u_frame (
    .clk   (clk),
    .we    (fwe),
    .waddr (flen[AW-1:0]),
    .wdata (rx_byte),
    .raddr (fraddr),
    .rdata (frd)
  );

  mbrtu_reg_mem #(.DEPTH(REG_COUNT)) u_regs (
    .clk   (clk),
    .en    (reg_en),
    .we    (reg_we),
    .addr  (reg_addr),
    .wdata (reg_wdata),
    .rdata (reg_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr        <= '0;
      flen       <= '0;
      fovf       <= 1'b0;
      dval       <= 1'b0;
      tx_valid   <= 1'b0;
      slave_addr <= SLAVE_ADDR_RST;
    end else begin
      if (cfg_valid) begin
        slave_addr <= slave_address;
      end
      if (!tx_stall) begin
        tx_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          if (clr == RAW'(REG_COUNT - 1)) begin
            state <= S_IDLE;
          end
          clr <= clr + RAW'(1);
        end
        S_IDLE: begin
          if (rx_acc) begin
            if (fwe) begin
              flen <= flen + LW'(1);
            end else begin
              fovf <= 1'b1;
            end
            if (frame_end) begin
              state  <= S_SCAN;
              rd_ptr <= '0;
              dval   <= 1'b0;
              fcrc   <= CRC_INIT;
            end
          end
        end
        S_SCAN: begin
          if (fovf || (flen < LW'(4))) begin
            state <= S_FIN;
          end else begin
            dval <= (rd_ptr != flen);
            didx <= rd_ptr;
            if (rd_ptr != flen) begin
              rd_ptr <= rd_ptr + LW'(1);
            end
            if (dval) begin
              if (didx < LW'(7)) begin
                hdr[didx[2:0]] <= frd;
              end
              if (({1'b0, didx} + (LW+1)'(2)) < {1'b0, flen}) begin
                fcrc <= crc16_byte(fcrc, frd);
              end
              if (didx == flen - LW'(2)) begin
                crc_lo_rx <= frd;
              end
              if (didx == flen - LW'(1)) begin
                crc_hi_rx <= frd;
                state     <= S_CHECK;
              end
            end
          end
        end
        S_CHECK: begin
          tidx <= '0;
          tcrc <= CRC_INIT;
          rptr <= start[RAW-1:0];
          rem  <= count[CW-1:0];
          fptr <= AW'(7);
          if (!hdr_ok) begin
            state <= S_FIN;
          end else if (fn_exc) begin
            kind  <= K_EXC;
            state <= S_HEAD;
          end else if (rd_ok) begin
            kind  <= K_READ;
            state <= S_HEAD;
          end else if (w1_ok) begin
            kind  <= K_ECHO;
            state <= S_HEAD;
          end else if (wn_ok) begin
            kind  <= K_ECHO;
            state <= S_WA;
          end else begin
            state <= S_FIN;
          end
        end
        S_WA: begin
          state <= S_WB;
        end
        S_WB: begin
          whi   <= frd;
          state <= S_WC;
        end
        S_WC: begin
          rptr <= rptr + RAW'(1);
          fptr <= fptr + AW'(2);
          rem  <= rem - CW'(1);
          if (rem == CW'(1)) begin
            state <= S_HEAD;
          end else begin
            state <= S_WA;
          end
        end
        S_HEAD: begin
          if (out_free) begin
            tx_valid <= 1'b1;
            tx_byte  <= head_byte;
            tx_last  <= 1'b0;
            tcrc     <= crc16_byte(tcrc, head_byte);
            tidx     <= tidx + 3'd1;
            if (tidx == head_end) begin
              state <= (kind == K_READ) ? S_RREQ : S_CRLO;
            end
          end
        end
        S_RREQ: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          state <= S_RHI;
        end
        S_RHI: begin
          if (out_free) begin
            tx_valid <= 1'b1;
            tx_byte  <= reg_rd[15:8];
            tx_last  <= 1'b0;
            tcrc     <= crc16_byte(tcrc, reg_rd[15:8]);
            state    <= S_RLO;
          end
        end
        S_RLO: begin
          if (out_free) begin
            tx_valid <= 1'b1;
            tx_byte  <= reg_rd[7:0];
            tx_last  <= 1'b0;
            tcrc     <= crc16_byte(tcrc, reg_rd[7:0]);
            rptr     <= rptr + RAW'(1);
            rem      <= rem - CW'(1);
            state    <= (rem == CW'(1)) ? S_CRLO : S_RREQ;
          end
        end
        S_CRLO: begin
          if (out_free) begin
            tx_valid <= 1'b1;
            tx_byte  <= tcrc[7:0];
            tx_last  <= 1'b0;
            state    <= S_CRHI;
          end
        end
        S_CRHI: begin
          if (out_free) begin
            tx_valid <= 1'b1;
            tx_byte  <= tcrc[15:8];
            tx_last  <= 1'b1;
            state    <= S_FIN;
          end
        end
        S_FIN: begin
          flen  <= '0;
          fovf  <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Nothing is transmitted while the register array is being cleared.
  a_clr_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !tx_valid)
    else $error("response word during register clearing pass");

  // The fill count never passes the frame store depth.
  a_flen_bound: assert property (@(posedge clk) disable iff (rst)
    flen <= LW'(FRAME_BYTES))
    else $error("frame length beyond frame store depth");

  // Scan data always belongs to a byte of the current frame.
  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && dval) |-> (didx < flen))
    else $error("scan index outside current frame");

  // Register writes stay inside the array.
  a_reg_addr: assert property (@(posedge clk) disable iff (rst)
    reg_we |-> ({1'b0, 16'(reg_addr)} < REG_LIM))
    else $error("holding register write out of range");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Modbus RTU holding-register server: frames are
// built byte by byte, predicted in a local register image, and every response
// word is compared against the predicted byte stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import mbrtu_pkg::*;

  localparam int NREGS    = REG_COUNT_DEF;
  localparam int FBYTES   = FRAME_BYTES_DEF;
  localparam int MAXREAD  = MAX_READ_REGS_DEF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = '0;
  logic       frame_end = 1'b0;
  logic       tx_valid;
  logic       tx_stall = 1'b0;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] slave_address = '0;

  // Local copy of the block's state, updated as each word is accepted.
  logic [15:0] reg_image [NREGS];
  logic [7:0]  rx_frame [FBYTES];
  int          rx_len;
  logic        rx_overflow;
  logic [7:0]  station;

  tx_word_t    pending_tx[$];
  int          errors = 0;
  int          stall_mode = 0;

  always #1 clk = ~clk;

  modbus_rtu_slave_register_server i_dut (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte), .frame_end(frame_end),
    .tx_valid(tx_valid), .tx_stall(tx_stall), .tx_byte(tx_byte), .tx_last(tx_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .slave_address(slave_address)
  );

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  // Append CRC (low byte first) to a response and queue its words.
  function automatic void queue_response(input logic [7:0] msg[$]);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (msg[i]) c = crc_step(c, msg[i]);
    msg.push_back(c[7:0]);
    msg.push_back(c[15:8]);
    foreach (msg[i]) pending_tx.push_back('{data: msg[i], last: (i == msg.size() - 1)});
  endfunction

  // Decide the response to the frame held in rx_frame, updating reg_image.
  function automatic void serve_frame();
    logic [7:0]  msg[$];
    logic [15:0] calc;
    logic [7:0]  fn;
    int          start, count;
    if (rx_overflow || rx_len < 4) return;
    if (rx_frame[0] != station) return;
    calc = CRC_INIT;
    for (int i = 0; i < rx_len - 2; i++) calc = crc_step(calc, rx_frame[i]);
    if (calc != {rx_frame[rx_len-1], rx_frame[rx_len-2]} &&
        calc != {rx_frame[rx_len-2], rx_frame[rx_len-1]}) return;
    fn = rx_frame[1];
    msg.push_back(station);
    if (fn == FN_COILS || fn == FN_INPUTS) begin
      msg.push_back(EXC_FLAG + fn);
      msg.push_back(EXC_ILLEGAL_FN);
      queue_response(msg);
      return;
    end
    if (fn != FN_READ_HOLD && fn != FN_WRITE_ONE && fn != FN_WRITE_MULTI) return;
    if (rx_len < 8) return;
    start = int'({rx_frame[2], rx_frame[3]});
    count = int'({rx_frame[4], rx_frame[5]});
    if (fn == FN_READ_HOLD) begin
      if (count == 0 || count > MAXREAD || start + count > NREGS) return;
      msg.push_back(FN_READ_HOLD);
      msg.push_back(8'(2 * count));
      for (int j = 0; j < count; j++) begin
        msg.push_back(reg_image[start + j][15:8]);
        msg.push_back(reg_image[start + j][7:0]);
      end
      queue_response(msg);
      return;
    end
    if (fn == FN_WRITE_ONE) begin
      if (start >= NREGS) return;
      reg_image[start] = 16'(count);
    end else begin
      if (rx_len < 9) return;
      if (rx_frame[6] != 2 * count) return;
      if (count == 0 || start + count > NREGS || 7 + 2 * count > rx_len - 2) return;
      for (int j = 0; j < count; j++)
        reg_image[start + j] = {rx_frame[7 + 2*j], rx_frame[8 + 2*j]};
    end
    msg.push_back(fn);
    for (int j = 2; j < 6; j++) msg.push_back(rx_frame[j]);
    queue_response(msg);
  endfunction

  function automatic void take_rx(input logic [7:0] b, input logic last);
    if (rx_len < FBYTES) begin
      rx_frame[rx_len] = b;
      rx_len++;
    end else begin
      rx_overflow = 1'b1;
    end
    if (last) begin
      serve_frame();
      rx_len = 0;
      rx_overflow = 1'b0;
    end
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Sends one word and waits until the block takes it. Valid stays high into
  // the next word when there is no gap.
  task automatic send_byte(input logic [7:0] b, input logic last, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      rx_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    rx_valid  <= 1'b1;
    rx_byte   <= b;
    frame_end <= last;
    do @(posedge clk); while (rx_stall);
    take_rx(b, last);
    // The block stalls after a frame end, so dropping valid here delays nothing.
    if (last) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] body[$], input int crc_mode, input bit gaps);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (body[i]) c = crc_step(c, body[i]);
    // crc_mode: 0 low first, 1 high first, 2 corrupted, 3 none appended
    if (crc_mode == 0) begin
      body.push_back(c[7:0]); body.push_back(c[15:8]);
    end else if (crc_mode == 1) begin
      body.push_back(c[15:8]); body.push_back(c[7:0]);
    end else if (crc_mode == 2) begin
      body.push_back(c[7:0] ^ 8'h5A); body.push_back(c[15:8]);
    end
    foreach (body[i]) send_byte(body[i], i == body.size() - 1, gaps);
  endtask

  task automatic wait_drain();
    int n;
    n = 0;
    while (pending_tx.size() != 0) @(posedge clk);
    // Frames with no response may still be in flight.
    while (n < 300) begin
      @(posedge clk);
      n = (rx_stall || tx_valid) ? 0 : n + 1;
      if (n >= 8) break;
    end
  endtask

  task automatic write_station(input logic [7:0] a);
    wait_drain();
    cfg_valid     <= 1'b1;
    slave_address <= a;
    do @(posedge clk); while (!cfg_ready);
    station = a;
    cfg_valid <= 1'b0;
  endtask

  function automatic void req6(output logic [7:0] q[$], input logic [7:0] fn,
                               input logic [15:0] a, input logic [15:0] b);
    q = {station, fn, a[15:8], a[7:0], b[15:8], b[7:0]};
  endfunction

  task automatic send_multi(input logic [15:0] start, input int count, input bit gaps);
    logic [7:0] q[$];
    logic [15:0] v;
    q = {station, FN_WRITE_MULTI, start[15:8], start[7:0], 8'h00, 8'(count), 8'(2 * count)};
    for (int j = 0; j < count; j++) begin
      v = 16'($urandom);
      q.push_back(v[15:8]); q.push_back(v[7:0]);
    end
    send_frame(q, $urandom_range(0, 1), gaps);
  endtask

  task automatic test_directed();
    logic [7:0] q[$];
    req6(q, FN_WRITE_ONE, 16'd0, 16'hFFFF);            send_frame(q, 0, 1);
    req6(q, FN_READ_HOLD, 16'd0, 16'd1);               send_frame(q, 0, 1);
    req6(q, FN_READ_HOLD, 16'd227, 16'd29);            send_frame(q, 0, 1);
    req6(q, FN_READ_HOLD, 16'd0, 16'd30);              send_frame(q, 0, 1);
    req6(q, FN_READ_HOLD, 16'd0, 16'd0);               send_frame(q, 0, 1);
    req6(q, FN_READ_HOLD, 16'd250, 16'd7);             send_frame(q, 0, 1);
    req6(q, FN_WRITE_ONE, 16'd256, 16'd5);             send_frame(q, 0, 1);
    q = {station, FN_COILS};                           send_frame(q, 2, 1);
    q = {station, FN_COILS};                           send_frame(q, 0, 1);
    q = {station, FN_INPUTS};                          send_frame(q, 1, 1);
    q = {station, 8'hFF, 8'h00};                       send_frame(q, 0, 1);
    q = {station, FN_READ_HOLD, 8'h00, 8'h01};         send_frame(q, 0, 1);
    q = {station};                                     send_frame(q, 3, 1);
    q = {8'(station + 8'd1), FN_COILS};                send_frame(q, 0, 1);
    send_multi(16'd248, 8, 1);
    send_multi(16'd253, 4, 1);
    q = {station, FN_WRITE_MULTI, 8'h00, 8'h02, 8'h00, 8'h02, 8'h03, 8'h11, 8'h22,
         8'h33, 8'h44};                                send_frame(q, 0, 1);
    q = {station, FN_WRITE_MULTI, 8'h00, 8'h02, 8'h00, 8'h02, 8'h04, 8'h11, 8'h22};
    send_frame(q, 0, 1);
    q = {station, FN_WRITE_MULTI, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h11};
    send_frame(q, 0, 1);
    // Overlong frame, dropped at its end.
    q = {};
    for (int i = 0; i < FBYTES + 3; i++) q.push_back(8'($urandom));
    q[0] = station;
    send_frame(q, 0, 1);
    req6(q, FN_READ_HOLD, 16'd240, 16'd16);            send_frame(q, 0, 1);
  endtask

  task automatic test_random(input int frames);
    logic [7:0] q[$];
    int kind, n;
    for (int f = 0; f < frames; f++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        req6(q, FN_READ_HOLD, 16'($urandom_range(0, 255)),
             16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6)));
        send_frame(q, ($urandom_range(0, 7) == 0) ? 2 : $urandom_range(0, 1), 1);
      end else if (kind < 6) begin
        req6(q, FN_WRITE_ONE,
             16'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 255)),
             16'($urandom));
        send_frame(q, $urandom_range(0, 1), 1);
      end else if (kind < 8) begin
        send_multi(16'($urandom_range(0, 255)), $urandom_range(1, 6), 1);
      end else begin
        q = {};
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) q.push_back(8'($urandom));
        if ($urandom_range(0, 1)) q[0] = station;
        if (n > 1 && $urandom_range(0, 1)) q[1] = 8'($urandom_range(0, 3));
        send_frame(q, $urandom_range(0, 3), 1);
      end
      // Hold off now and then until every response has left.
      if ($urandom_range(0, 19) == 0) wait_drain();
    end
  endtask

  // Checker: every accepted tx word is compared with the oldest expectation.
  always @(posedge clk) begin
    tx_word_t exp_w;
    if (!rst && tx_valid && !tx_stall) begin
      if (pending_tx.size() == 0) begin
        $display("%0t: unexpected word expected none actual byte %02h last %0b",
                 $time, tx_byte, tx_last);
        errors++;
      end else begin
        exp_w = pending_tx.pop_front();
        if (exp_w.data !== tx_byte) begin
          $display("%0t: tx_byte expected %02h actual %02h", $time, exp_w.data, tx_byte);
          errors++;
        end
        if (exp_w.last !== tx_last) begin
          $display("%0t: tx_last expected %0b actual %0b", $time, exp_w.last, tx_last);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure: gaps of random length, with stall-free stretches.
  always @(posedge clk) begin
    if (stall_mode == 0) tx_stall <= 1'b0;
    else if ($urandom_range(0, 3) == 0)
      tx_stall <= ($urandom_range(0, 15) == 0) ? 1'b1 : ~tx_stall;
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 1);
  end

  initial begin
    foreach (reg_image[i]) reg_image[i] = '0;
    rx_len = 0;
    rx_overflow = 1'b0;
    station = SLAVE_ADDR_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    write_station(8'h5C);
    test_random(2);
    wait_drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_tx.size() == 0) begin
      $display("modbus_rtu_slave_register_server: match");
    end else begin
      $display("modbus_rtu_slave_register_server: mismatch");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("modbus_rtu_slave_register_server: mismatch");
    $finish;
  end

endmodule
